// ----- rtl/core/wsd_pkg.sv -----
// Shared types and constants for the websocket frame deframer.
// No dependencies; used by every module under rtl/core.
`default_nettype none

package wsd_pkg;

  // Default width of the frame length and payload down-counter
  localparam int DEF_LENGTH_BITS = 64;

  // Opcodes with side effects
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;

  // Second header byte: length codes that announce an extended length
  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  // Number of extended length bytes
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;

  // Index of the last of the four mask key bytes
  localparam logic [1:0] MASK_LAST = 2'd3;

  // One result item
  typedef struct packed {
    logic       byte_valid;
    logic [7:0] payload_byte;
    logic       frame_end;
    logic [3:0] frame_opcode;
    logic       final_fragment;
    logic       send_pong;
    logic       close_received;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/websocket_frame_deframer.sv -----
// Top level of the websocket frame deframer: input register, parser, result register.
// Depends on wsd_pkg, wsd_parser and wsd_out_reg.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  input   | in_valid, in_stall, in_byte             | in (stall out)
//  result  | out_valid, out_stall, out_byte_valid .. | out (stall in)
//          | out_close_received                      |
//
// One byte per cycle is taken while in_stall is low; a result passes through the
// input register, then the result register. Header, length and mask bytes that
// give no result pass through without touching the output side.
// Synchronous active-low reset returns the parser to the first header byte.
// in_stall rises only when the input register holds a byte with a result and
// the result register is full and stalled.
`default_nettype none

module websocket_frame_deframer #(
  parameter int LENGTH_BITS = wsd_pkg::DEF_LENGTH_BITS
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_byte_valid,
  output logic [7:0]      out_payload_byte,
  output logic            out_frame_end,
  output logic [3:0]      out_frame_opcode,
  output logic            out_final_fragment,
  output logic            out_send_pong,
  output logic            out_close_received
);

  logic             s1_valid_r;
  logic [7:0]       s1_byte_r;
  logic             s1_adv;
  logic             res_valid;
  logic             out_ready;
  wsd_pkg::result_t res;
  wsd_pkg::result_t out_res;

  // Input register moves on when its byte has no result or the output can take it
  assign s1_adv   = !res_valid || out_ready;
  assign in_stall = s1_valid_r && !s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_byte;
    end
  end

  wsd_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (s1_valid_r && s1_adv),
    .item_byte (s1_byte_r),
    .res_valid (res_valid),
    .res       (res)
  );

  wsd_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (s1_valid_r && res_valid),
    .load_res   (res),
    .ready      (out_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (out_res)
  );

  // Result fields onto their ports
  assign out_byte_valid     = out_res.byte_valid;
  assign out_payload_byte   = out_res.payload_byte;
  assign out_frame_end      = out_res.frame_end;
  assign out_frame_opcode   = out_res.frame_opcode;
  assign out_final_fragment = out_res.final_fragment;
  assign out_send_pong      = out_res.send_pong;
  assign out_close_received = out_res.close_received;

endmodule

`default_nettype wire

// ----- rtl/core/wsd_parser.sv -----
// Frame parser: header, extended length, mask key and payload unmasking.
// Holds all per-frame state; uses wsd_pkg for codes and the result type.
`default_nettype none

module wsd_parser #(
  parameter int LENGTH_BITS = wsd_pkg::DEF_LENGTH_BITS
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             fire,       // byte consumed this cycle
  input  wire logic [7:0]       item_byte,
  output logic                  res_valid,  // this byte yields a result
  output wsd_pkg::result_t      res
);

  typedef enum logic [4:0] {
    PH_HEADER  = 5'b00001,
    PH_LEN16   = 5'b00010,
    PH_LEN64   = 5'b00100,
    PH_MASK    = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_t;

  phase_t                 phase_r,   phase_nxt;
  logic [3:0]             hdr_cnt_r, hdr_cnt_nxt;
  logic [7:0]             first_r,   first_nxt;
  logic                   mask_r,    mask_nxt;
  logic [LENGTH_BITS-1:0] remain_r,  remain_nxt;  // bytes left in frame
  logic [31:0]            key_r,     key_nxt;
  logic [1:0]             mcnt_r,    mcnt_nxt;
  logic [1:0]             mpos_r,    mpos_nxt;
  logic                   close_r,   close_nxt;

  logic [6:0] len_code;
  logic       len_done;
  logic       emit;
  logic       emit_data;
  logic       emit_end;
  logic [7:0] key_byte;
  logic [3:0] op;

  assign op       = first_r[3:0];
  assign len_code = item_byte[6:0];

  // Current mask byte, first key byte first
  always_comb begin
    case (mpos_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  // Next state and result for the byte in the input register
  always_comb begin
    phase_nxt   = phase_r;
    hdr_cnt_nxt = hdr_cnt_r;
    first_nxt   = first_r;
    mask_nxt    = mask_r;
    remain_nxt  = remain_r;
    key_nxt     = key_r;
    mcnt_nxt    = mcnt_r;
    mpos_nxt    = mpos_r;
    close_nxt   = close_r;
    len_done    = 1'b0;
    emit        = 1'b0;
    emit_data   = 1'b0;
    emit_end    = 1'b0;

    case (phase_r)
      PH_LEN16, PH_LEN64: begin
        remain_nxt  = {remain_r[LENGTH_BITS-9:0], item_byte};
        hdr_cnt_nxt = hdr_cnt_r + 4'd1;
        if (hdr_cnt_nxt >= ((phase_r == PH_LEN16) ? wsd_pkg::EXT16_BYTES
                                                   : wsd_pkg::EXT64_BYTES)) begin
          len_done = 1'b1;
        end
      end
      PH_MASK: begin
        key_nxt  = {key_r[23:0], item_byte};
        mcnt_nxt = mcnt_r + 2'd1;
        if (mcnt_r == wsd_pkg::MASK_LAST) begin
          if (remain_r == '0) begin
            emit     = 1'b1;
            emit_end = 1'b1;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        mpos_nxt   = mpos_r + 2'd1;
        remain_nxt = remain_r - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
        emit       = 1'b1;
        emit_data  = 1'b1;
        emit_end   = (remain_r == {{(LENGTH_BITS-1){1'b0}}, 1'b1});
      end
      default: begin
        // Header bytes; an unknown phase is treated as header
        phase_nxt = PH_HEADER;
        if (hdr_cnt_r == 4'd0) begin
          first_nxt   = item_byte;
          hdr_cnt_nxt = 4'd1;
        end else begin
          mask_nxt    = item_byte[7];
          hdr_cnt_nxt = 4'd0;
          remain_nxt  = '0;
          if (len_code == wsd_pkg::LEN_CODE_16) begin
            phase_nxt = PH_LEN16;
          end else if (len_code == wsd_pkg::LEN_CODE_64) begin
            phase_nxt = PH_LEN64;
          end else begin
            remain_nxt = {{(LENGTH_BITS-7){1'b0}}, len_code};
            len_done   = 1'b1;
          end
        end
      end
    endcase

    // Length known: go for the mask key, the payload, or finish at once
    if (len_done) begin
      if (mask_nxt) begin
        phase_nxt = PH_MASK;
        mcnt_nxt  = 2'd0;
      end else if (remain_nxt == '0) begin
        emit     = 1'b1;
        emit_end = 1'b1;
      end else begin
        phase_nxt = PH_PAYLOAD;
      end
    end

    // Frame end: sticky close flag and restart of the parse
    if (emit_end) begin
      if (op == wsd_pkg::OP_CLOSE) begin
        close_nxt = 1'b1;
      end
      phase_nxt   = PH_HEADER;
      hdr_cnt_nxt = 4'd0;
      mcnt_nxt    = 2'd0;
      mpos_nxt    = 2'd0;
    end
  end

  // Result fields
  always_comb begin
    res.byte_valid     = emit_data;
    res.payload_byte   = emit_data ? (item_byte ^ (mask_r ? key_byte : 8'h00)) : 8'h00;
    res.frame_end      = emit_end;
    res.frame_opcode   = op;
    res.final_fragment = first_r[7];
    res.send_pong      = emit_end && (op == wsd_pkg::OP_PING) && !close_r;
    res.close_received = close_nxt;
  end

  assign res_valid = emit;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      hdr_cnt_r <= 4'd0;
      first_r   <= 8'h00;
      mask_r    <= 1'b0;
      remain_r  <= '0;
      key_r     <= 32'h0;
      mcnt_r    <= 2'd0;
      mpos_r    <= 2'd0;
      close_r   <= 1'b0;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      first_r   <= first_nxt;
      mask_r    <= mask_nxt;
      remain_r  <= remain_nxt;
      key_r     <= key_nxt;
      mcnt_r    <= mcnt_nxt;
      mpos_r    <= mpos_nxt;
      close_r   <= close_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/wsd_out_reg.sv -----
// Result register on the output channel with valid/stall handshake.
// Uses wsd_pkg::result_t.
`default_nettype none

module wsd_out_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load_valid,
  input  wire wsd_pkg::result_t  load_res,
  output logic                   ready,      // register can take a result
  output logic                   out_valid,
  input  wire logic              out_stall,
  output wsd_pkg::result_t       out_res
);

  logic             valid_r;
  wsd_pkg::result_t res_r;

  assign ready     = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  // Valid flag: refilled or emptied whenever the held result is gone
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready) begin
      valid_r <= load_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (ready && load_valid) begin
      res_r <= load_res;
    end
  end

endmodule

`default_nettype wire

// ----- dv/tb_websocket_frame_deframer.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for websocket_frame_deframer: frames go in as a byte stream,
// payload bytes and frame status come out. Depends on wsd_pkg and the deframer RTL.

module tb_websocket_frame_deframer;

  localparam int LEN_BITS = wsd_pkg::DEF_LENGTH_BITS;
  localparam logic [63:0] LEN_MASK = {64{1'b1}} >> (64 - LEN_BITS);
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned RANDOM_BYTES = 800;
  localparam int unsigned HOLDOFF_CYCLES = 400;

  // Opcodes without side effects
  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_PONG   = 4'hA;

  typedef enum logic [2:0] {PH_HDR, PH_EXT16, PH_EXT64, PH_KEY, PH_DATA} phase_t;
  typedef enum int {FORM_SHORT, FORM_EXT16, FORM_EXT64} len_form_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_byte_valid;
  logic [7:0] out_payload_byte;
  logic       out_frame_end;
  logic [3:0] out_frame_opcode;
  logic       out_final_fragment;
  logic       out_send_pong;
  logic       out_close_received;

  // Parser state as the stream has been consumed so far
  phase_t      rx_phase = PH_HDR;
  logic [3:0]  hdr_cnt = '0;
  logic [7:0]  hdr_first = '0;
  logic        masked = 1'b0;
  logic [6:0]  len_code = '0;
  logic [63:0] frame_len = '0;
  logic [63:0] data_cnt = '0;
  logic [31:0] key_word = '0;
  logic [1:0]  key_cnt = '0;
  logic [1:0]  key_pos = '0;
  logic        close_seen = 1'b0;

  wsd_pkg::result_t pending_results[$];
  int unsigned error_count = 0;
  int unsigned results_seen = 0;
  int unsigned bytes_sent = 0;
  int unsigned cycle_count = 0;
  bit          idle_on = 1'b1;
  bit          sink_idle_on = 1'b1;
  int unsigned sink_wait = 0;
  int unsigned hold_left = 0;

  websocket_frame_deframer #(
    .LENGTH_BITS(LEN_BITS)
  ) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_byte            (in_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte_valid     (out_byte_valid),
    .out_payload_byte   (out_payload_byte),
    .out_frame_end      (out_frame_end),
    .out_frame_opcode   (out_frame_opcode),
    .out_final_fragment (out_final_fragment),
    .out_send_pong      (out_send_pong),
    .out_close_received (out_close_received)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Frame parser prediction
  // ---------------------------------------------------------------------------

  // Queue one result; a frame end also handles close/ping and rearms the header
  task automatic emit_result(input logic valid, input logic [7:0] data, input logic last);
    wsd_pkg::result_t r;
    logic [3:0]       op;
    op = hdr_first[3:0];
    r.send_pong = 1'b0;
    if (last) begin
      if (op == wsd_pkg::OP_CLOSE) close_seen = 1'b1;
      if (op == wsd_pkg::OP_PING && !close_seen) r.send_pong = 1'b1;
    end
    r.byte_valid     = valid;
    r.payload_byte   = valid ? data : 8'h00;
    r.frame_end      = last;
    r.frame_opcode   = op;
    r.final_fragment = hdr_first[7];
    r.close_received = close_seen;
    pending_results.push_back(r);
    if (last) begin
      rx_phase = PH_HDR;
      hdr_cnt  = '0;
      key_cnt  = '0;
      key_pos  = '0;
      data_cnt = '0;
    end
  endtask

  // Length fully known: mask key next, or payload, or an empty frame ends here
  task automatic length_known();
    if (masked) begin
      rx_phase = PH_KEY;
      key_cnt  = '0;
    end else if (frame_len == 0) begin
      emit_result(1'b0, 8'h00, 1'b1);
    end else begin
      rx_phase = PH_DATA;
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    logic [7:0] key;
    case (rx_phase)
      PH_EXT16, PH_EXT64: begin
        frame_len = ((frame_len << 8) | 64'(b)) & LEN_MASK;
        hdr_cnt++;
        if (hdr_cnt >= (rx_phase == PH_EXT16 ? wsd_pkg::EXT16_BYTES
                                             : wsd_pkg::EXT64_BYTES)) length_known();
      end
      PH_KEY: begin
        key_word = {key_word[23:0], b};
        if (key_cnt == wsd_pkg::MASK_LAST) begin
          key_cnt = '0;
          if (frame_len == 0) emit_result(1'b0, 8'h00, 1'b1);
          else rx_phase = PH_DATA;
        end else begin
          key_cnt++;
        end
      end
      PH_DATA: begin
        // key bytes rotate, most significant first
        key = masked ? key_word[8 * (3 - int'(key_pos)) +: 8] : 8'h00;
        key_pos++;
        data_cnt++;
        emit_result(1'b1, b ^ key, data_cnt >= frame_len);
      end
      default: begin
        rx_phase = PH_HDR;
        if (hdr_cnt == 0) begin
          hdr_first = b;
          hdr_cnt   = 4'd1;
        end else begin
          masked    = b[7];
          len_code  = b[6:0];
          hdr_cnt   = '0;
          frame_len = '0;
          if (len_code == wsd_pkg::LEN_CODE_16) begin
            rx_phase = PH_EXT16;
          end else if (len_code == wsd_pkg::LEN_CODE_64) begin
            rx_phase = PH_EXT64;
          end else begin
            frame_len = 64'(len_code) & LEN_MASK;
            length_known();
          end
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Byte source, result sink and checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %0h expected %0h",
                                results_seen, name, got, want));
  endtask

  // Offer one byte after a random gap; hold it until the transfer completes
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    deframe_byte(b);
    bytes_sent++;
  endtask

  // Sender stops and waits for every outstanding result
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_frame(input logic [7:0] first, input logic mask_on, input len_form_t form,
                            input logic [63:0] len, input logic [31:0] key);
    logic [6:0] code;
    case (form)
      FORM_EXT16: code = wsd_pkg::LEN_CODE_16;
      FORM_EXT64: code = wsd_pkg::LEN_CODE_64;
      default:    code = len[6:0];
    endcase
    send_byte(first);
    send_byte({mask_on, code});
    if (form == FORM_EXT16) for (int i = 1; i >= 0; i--) send_byte(len[8 * i +: 8]);
    if (form == FORM_EXT64) for (int i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
    if (mask_on) for (int i = 3; i >= 0; i--) send_byte(key[8 * i +: 8]);
    for (int n = 0; n < int'(len); n++) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_random_frame(input logic close_allowed);
    logic [7:0]  first;
    logic [3:0]  op;
    logic        mask_on;
    len_form_t   form;
    int          len;
    logic [31:0] key;
    int          pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1:    op = OP_TEXT;
      2, 3:    op = OP_BINARY;
      4:       op = OP_CONT;
      5:       op = wsd_pkg::OP_PING;
      6:       op = OP_PONG;
      7:       op = wsd_pkg::OP_CLOSE;
      default: op = 4'($urandom_range(0, 15));
    endcase
    if (!close_allowed && op == wsd_pkg::OP_CLOSE) op = wsd_pkg::OP_PING;
    first   = {1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), op};
    mask_on = ($urandom_range(0, 3) != 0);
    // mostly short payloads, a few beyond the 7-bit code
    pick = $urandom_range(0, 99);
    if (pick < 8) len = 0;
    else if (pick < 85) len = $urandom_range(1, 20);
    else if (pick < 96) len = $urandom_range(21, 125);
    else len = $urandom_range(126, 300);
    pick = $urandom_range(0, 9);
    if (len > 125) form = (pick < 7) ? FORM_EXT16 : FORM_EXT64;
    else if (pick < 8) form = FORM_SHORT;
    else if (pick == 8) form = FORM_EXT16;
    else form = FORM_EXT64;
    pick = $urandom_range(0, 9);
    key = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : 32'($urandom());
    idle_on = ($urandom_range(0, 4) != 0);
    send_frame(first, mask_on, form, 64'(len), key);
  endtask

  // Result sink: a long hold-off takes priority over the per-transfer wait
  initial begin : result_sink
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (sink_wait != 0) begin
        out_stall <= 1'b1;
        sink_wait--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Compare every result transfer against the oldest prediction
  always @(posedge clk) begin : result_check
    wsd_pkg::result_t got;
    wsd_pkg::result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      got = {out_byte_valid, out_payload_byte, out_frame_end, out_frame_opcode,
             out_final_fragment, out_send_pong, out_close_received};
      sink_wait = sink_idle_on ? $urandom_range(0, 3) : 0;
      if ($urandom_range(0, 31) == 0) sink_idle_on = !sink_idle_on;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", got));
      end else begin
        want = pending_results.pop_front();
        check_field("byte_valid", 8'(got.byte_valid), 8'(want.byte_valid));
        check_field("payload_byte", got.payload_byte, want.payload_byte);
        check_field("frame_end", 8'(got.frame_end), 8'(want.frame_end));
        check_field("frame_opcode", 8'(got.frame_opcode), 8'(want.frame_opcode));
        check_field("final_fragment", 8'(got.final_fragment), 8'(want.final_fragment));
        check_field("send_pong", 8'(got.send_pong), 8'(want.send_pong));
        check_field("close_received", 8'(got.close_received), 8'(want.close_received));
      end
      results_seen++;
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty ping, all-zero and all-one header bytes, masked empty and short frames
  task automatic test_control_frames();
    idle_on = 1'b1;
    send_frame({1'b1, 3'b000, wsd_pkg::OP_PING}, 1'b0, FORM_SHORT, 64'd0, 32'h0);
    send_frame({1'b0, 3'b000, OP_CONT}, 1'b0, FORM_SHORT, 64'd1, 32'h0);
    send_frame(8'hFF, 1'b1, FORM_SHORT, 64'd0, 32'hFFFF_FFFF);
    send_frame({1'b1, 3'b000, OP_PONG}, 1'b1, FORM_SHORT, 64'd2, 32'h0);
    wait_drained();
  endtask

  // Key rotation wraps past four bytes; ping with payload ends with a pong
  task automatic test_masked_payload();
    send_frame({1'b1, 3'b000, OP_TEXT}, 1'b1, FORM_SHORT, 64'd6, 32'h37FA_213D);
    send_frame({1'b1, 3'b000, wsd_pkg::OP_PING}, 1'b1, FORM_SHORT, 64'd3, 32'hA5C3_0F81);
    wait_drained();
  endtask

  // Empty frame via a 16-bit length, short payload via a 64-bit length
  task automatic test_extended_lengths();
    send_frame({1'b1, 3'b000, OP_BINARY}, 1'b0, FORM_EXT16, 64'd0, 32'h0);
    send_frame({1'b0, 3'b000, OP_TEXT}, 1'b1, FORM_EXT64, 64'd2, 32'h1234_5678);
    wait_drained();
  endtask

  // Random traffic while no close has been seen, so pings still get pongs
  task automatic test_random_open();
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) send_random_frame(1'b0);
    wait_drained();
  endtask

  // Close sets the sticky flag; pings after it no longer ask for a pong
  task automatic test_close_frame();
    idle_on = 1'b1;
    send_frame({1'b1, 3'b000, wsd_pkg::OP_PING}, 1'b0, FORM_SHORT, 64'd1, 32'h0);
    send_frame({1'b1, 3'b000, wsd_pkg::OP_CLOSE}, 1'b1, FORM_SHORT, 64'd0, 32'hDEAD_BEEF);
    send_frame({1'b1, 3'b000, wsd_pkg::OP_PING}, 1'b0, FORM_SHORT, 64'd0, 32'h0);
    send_frame({1'b1, 3'b000, wsd_pkg::OP_CLOSE}, 1'b0, FORM_SHORT, 64'd2, 32'h0);
    wait_drained();
  endtask

  task automatic test_random_closed();
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) send_random_frame(1'b1);
    wait_drained();
  endtask

  // Sink stalls for a long stretch while payload keeps coming, filling the block
  task automatic test_result_holdoff();
    idle_on   = 1'b0;
    hold_left = HOLDOFF_CYCLES;
    send_frame({1'b1, 3'b000, OP_BINARY}, 1'b1, FORM_SHORT, 64'd100, 32'($urandom()));
    wait_drained();
  endtask

  initial begin : test_sequence
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_control_frames();
    test_masked_payload();
    test_extended_lengths();
    test_random_open();
    test_close_frame();
    test_random_closed();
    test_result_holdoff();
    if (error_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
